// ===== hw/rtl/murmur64b_hash_unit_macros.svh =====
// Assertion macros for the murmur64b hash unit.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef MURMUR64B_HASH_UNIT_MACROS_SVH
`define MURMUR64B_HASH_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define MM64B_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("murmur64b hash unit: check failed");

// Next-cycle implication.
`define MM64B_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("murmur64b hash unit: check failed");

`endif

// ===== hw/rtl/mm64b_pkg.sv =====
// Shared constants, types and the mixing multiply of the murmur64b hash unit.
// No dependencies.
package mm64b_pkg;

  localparam logic [31:0] MixMult   = 32'h5bd1e995;
  localparam int unsigned MixShift  = 24;
  localparam int unsigned FinShift0 = 18;
  localparam int unsigned FinShift1 = 22;
  localparam int unsigned FinShift2 = 17;
  localparam int unsigned FinShift3 = 19;
  localparam logic [31:0] SeedReset = 32'hEE6B27EB;
  localparam int unsigned QueueDepthDefault = 4;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_FULL = 2'd1,
    KIND_PART = 2'd2
  } word_kind_e;

  // One classified request on its way from the front to the back.
  typedef struct packed {
    logic [31:0] key;   // mixed word (full) or masked tail (partial)
    word_kind_e  kind;
    logic        last;
    logic        start; // first word of a message
    logic [31:0] init;  // seed xor total length
  } item_t;

  function automatic logic [31:0] mul_mix(input logic [31:0] a);
    logic [63:0] p;
    p = {32'd0, a} * {32'd0, MixMult};
    return p[31:0];
  endfunction

endpackage

// ===== hw/rtl/mm64b_front.sv =====
// Front end: takes requests, classifies them and mixes full words in two stages.
// Depends on mm64b_pkg.
module mm64b_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [31:0]          data_word_i,
  input  logic [2:0]           valid_bytes_i,
  input  logic                 last_word_i,
  input  logic [30:0]          total_length_i,
  input  logic [31:0]          seed_i,
  output logic                 item_valid_o,
  output mm64b_pkg::item_t     item_o,
  output logic [1:0]           inflight_o
);

  logic             in_msg_q, in_msg_d;
  logic             v1_q, v2_q;
  mm64b_pkg::item_t s1_q, s1_d, s2_q, s2_d;
  logic [31:0]      mask;
  logic [31:0]      k1;

  always_comb begin
    case (valid_bytes_i)
      3'd1:    mask = 32'h0000_00FF;
      3'd2:    mask = 32'h0000_FFFF;
      3'd3:    mask = 32'h00FF_FFFF;
      default: mask = 32'hFFFF_FFFF;
    endcase
  end

  always_comb begin
    s1_d.last  = last_word_i;
    s1_d.start = !in_msg_q;
    s1_d.init  = seed_i ^ {1'b0, total_length_i};
    if (valid_bytes_i == 3'd0) begin
      s1_d.kind = mm64b_pkg::KIND_NONE;
      s1_d.key  = data_word_i;
    end else if (valid_bytes_i[2]) begin
      s1_d.kind = mm64b_pkg::KIND_FULL;
      s1_d.key  = mm64b_pkg::mul_mix(data_word_i);
    end else begin
      s1_d.kind = mm64b_pkg::KIND_PART;
      s1_d.key  = data_word_i & mask;
    end
  end

  // Second mixing multiply on full words; other kinds pass unchanged.
  always_comb begin
    k1     = s1_q.key ^ (s1_q.key >> mm64b_pkg::MixShift);
    s2_d   = s1_q;
    if (s1_q.kind == mm64b_pkg::KIND_FULL) begin
      s2_d.key = mm64b_pkg::mul_mix(k1);
    end
  end

  assign in_msg_d = accept_i ? !last_word_i : in_msg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_msg_q <= 1'b0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
    end else begin
      in_msg_q <= in_msg_d;
      v1_q     <= accept_i;
      v2_q     <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
    s2_q <= s2_d;
  end

  assign item_valid_o = v2_q;
  assign item_o       = s2_q;
  assign inflight_o   = {1'b0, v1_q} + {1'b0, v2_q};

endmodule

// ===== hw/rtl/mm64b_queue.sv =====
// Short request queue between front and back end.
// Depends on mm64b_pkg.
module mm64b_queue #(
  parameter int unsigned Depth = mm64b_pkg::QueueDepthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  mm64b_pkg::item_t            item_i,
  input  logic                        pop_i,
  output logic                        valid_o,
  output mm64b_pkg::item_t            item_o,
  output logic [$clog2(Depth+1)-1:0]  count_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  mm64b_pkg::item_t  store_q [Depth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_pop;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign do_pop = pop_i && (cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ptr_next(wr_q);
      if (do_pop) rd_q <= ptr_next(rd_q);
      cnt_q <= cnt_q + CntW'(push_i) - CntW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) store_q[wr_q] <= item_i;
  end

  assign valid_o = (cnt_q != '0);
  assign item_o  = store_q[rd_q];
  assign count_o = cnt_q;

endmodule

// ===== hw/rtl/mm64b_back.sv =====
// Back end: accumulator update, four-round finalization and result register.
// Depends on mm64b_pkg; shares one constant multiplier across all steps.
module mm64b_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  input  mm64b_pkg::item_t  item_i,
  output logic              item_pop_o,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [63:0]       hash_value_o
);

  typedef enum logic [2:0] {
    ST_RUN = 3'b001,
    ST_FIN = 3'b010,
    ST_OUT = 3'b100
  } back_state_e;

  back_state_e state_q, state_d;
  logic [31:0] hi_q, hi_d, lo_q, lo_d;
  logic        par_q, par_d;
  logic [1:0]  rnd_q, rnd_d;
  logic        out_v_q, out_v_d;
  logic [63:0] out_q;
  logic        load;
  logic [31:0] base_hi, base_lo;
  logic        base_par;
  logic [31:0] mul_a, prod;

  assign base_hi  = item_i.start ? item_i.init : hi_q;
  assign base_lo  = item_i.start ? 32'd0 : lo_q;
  assign base_par = item_i.start ? 1'b0 : par_q;
  assign prod     = mm64b_pkg::mul_mix(mul_a);

  always_comb begin
    state_d    = state_q;
    hi_d       = hi_q;
    lo_d       = lo_q;
    par_d      = par_q;
    rnd_d      = rnd_q;
    mul_a      = 32'd0;
    item_pop_o = 1'b0;
    load       = 1'b0;
    case (state_q)
      ST_RUN: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          hi_d       = base_hi;
          lo_d       = base_lo;
          par_d      = base_par;
          case (item_i.kind)
            mm64b_pkg::KIND_FULL: begin
              mul_a = base_par ? base_lo : base_hi;
              if (base_par) lo_d = prod ^ item_i.key;
              else          hi_d = prod ^ item_i.key;
              par_d = !base_par;
            end
            mm64b_pkg::KIND_PART: begin
              mul_a = base_lo ^ item_i.key;
              lo_d  = prod;
            end
            default: ;
          endcase
          if (item_i.last) begin
            state_d = ST_FIN;
            rnd_d   = 2'd0;
          end
        end
      end
      ST_FIN: begin
        rnd_d = rnd_q + 2'd1;
        case (rnd_q)
          2'd0: begin
            mul_a = hi_q ^ (lo_q >> mm64b_pkg::FinShift0);
            hi_d  = prod;
          end
          2'd1: begin
            mul_a = lo_q ^ (hi_q >> mm64b_pkg::FinShift1);
            lo_d  = prod;
          end
          2'd2: begin
            mul_a = hi_q ^ (lo_q >> mm64b_pkg::FinShift2);
            hi_d  = prod;
          end
          default: begin
            mul_a   = lo_q ^ (hi_q >> mm64b_pkg::FinShift3);
            lo_d    = prod;
            state_d = ST_OUT;
          end
        endcase
      end
      ST_OUT: begin
        // Hold until the result register is free or drains this cycle.
        if (!out_v_q || pop_i) begin
          load    = 1'b1;
          hi_d    = 32'd0;
          lo_d    = 32'd0;
          par_d   = 1'b0;
          state_d = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  always_comb begin
    out_v_d = out_v_q;
    if (pop_i) out_v_d = 1'b0;
    if (load) out_v_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
      hi_q    <= 32'd0;
      lo_q    <= 32'd0;
      par_q   <= 1'b0;
      rnd_q   <= 2'd0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      hi_q    <= hi_d;
      lo_q    <= lo_d;
      par_q   <= par_d;
      rnd_q   <= rnd_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) out_q <= {hi_q, lo_q};
  end

  assign empty_o      = !out_v_q;
  assign hash_value_o = out_q;

endmodule

// ===== hw/rtl/murmur64b_hash_unit.sv =====
// Top level of the murmur64b hash unit: seed register, front, queue, back.
// Depends on mm64b_pkg, mm64b_front, mm64b_queue, mm64b_back and the macro header.
//
//   channel   direction  handshake            payload
//   message   in         push / full          data_word_i, valid_bytes_i,
//                                             last_word_i, total_length_i
//   hash      out        empty / pop          hash_value_o
//   config    in         psel/penable/pready  paddr, pwdata, prdata (hash_seed)
//
// A request passes through the front stages (one stage per mixing multiply),
// then the back end takes one word per cycle while it is not finalizing or
// holding a result, using the single shared multiplier. After the last word
// of a message the back end runs the finalization rounds, then loads the
// result register. Reset clears the message state, queue and result valid
// flag; the seed returns to 0xEE6B27EB. full rises when queue plus front
// stages hold QueueDepth requests; a waiting result stalls only the back end.
`include "murmur64b_hash_unit_macros.svh"

module murmur64b_hash_unit #(
  parameter int unsigned QueueDepth = mm64b_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // message words
  input  logic        push,
  output logic        full,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  valid_bytes_i,
  input  logic        last_word_i,
  input  logic [30:0] total_length_i,
  // hash results
  output logic        empty,
  input  logic        pop,
  output logic [63:0] hash_value_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam int unsigned OccW = CntW + 1;

  logic [31:0]      seed_q;
  logic             accept;
  logic             fe_valid;
  mm64b_pkg::item_t fe_item;
  logic [1:0]       inflight;
  logic             q_valid;
  mm64b_pkg::item_t q_item;
  logic [CntW-1:0]  q_count;
  logic             q_pop;
  logic [OccW-1:0]  occ;

  // Seed register: one register, decoded on paddr[2] == 0 (byte addresses 0 to 3).
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? seed_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= mm64b_pkg::SeedReset;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      seed_q <= pwdata;
    end
  end

  // Reserve queue space for every request still in the front stages.
  assign occ    = OccW'(q_count) + OccW'(inflight);
  assign full   = (occ >= OccW'(QueueDepth));
  assign accept = push && !full;

  mm64b_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .data_word_i    (data_word_i),
    .valid_bytes_i  (valid_bytes_i),
    .last_word_i    (last_word_i),
    .total_length_i (total_length_i),
    .seed_i         (seed_q),
    .item_valid_o   (fe_valid),
    .item_o         (fe_item),
    .inflight_o     (inflight)
  );

  mm64b_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_valid),
    .item_i  (fe_item),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item),
    .count_o (q_count)
  );

  mm64b_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .item_pop_o   (q_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .hash_value_o (hash_value_o)
  );

  // Credit accounting never lets the queue plus front stages overfill.
  `MM64B_ASSERT_IMP(a_occ_bound, 1'b1, occ <= OccW'(QueueDepth))
  // A request leaving the front always finds a free queue slot.
  `MM64B_ASSERT_IMP(a_no_overflow, fe_valid, q_count < CntW'(QueueDepth))
  // An accepted request shows up as in flight in the next cycle.
  `MM64B_ASSERT_NXT(a_accept_tracked, accept, inflight != 2'd0)

endmodule
